[design/sbcd_pkg.sv]
// Shared constants and types for the start-byte checksum deframer.
package sbcd_pkg;

  localparam int DATA_BYTES = 4;
  localparam int IDX_W      = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
  localparam int CNT_W      = $clog2(DATA_BYTES + 1);
  localparam int ADDR_W     = IDX_W + 1;
  localparam int BYTE_W     = 8;
  localparam int BIDX_W     = 4;
  localparam logic [BYTE_W-1:0] START_RESET = 8'd126;

  typedef struct packed {
    logic commit;
    logic bank;
  } sbcd_commit_t;

endpackage

[design/sbcd_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
module sbcd_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/sbcd_rx.sv]
// Receive side: start hunt, byte storage into the frame RAM and checksum compare.
module sbcd_rx (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [sbcd_pkg::BYTE_W-1:0]  cfg_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sbcd_pkg::BYTE_W-1:0]  s_tdata,
  input  logic [1:0]                   bank_full,
  output logic                         we,
  output logic [sbcd_pkg::ADDR_W-1:0]  waddr,
  output logic [sbcd_pkg::BYTE_W-1:0]  wdata,
  output sbcd_pkg::sbcd_commit_t       commit
);
  import sbcd_pkg::*;

  logic [BYTE_W-1:0] start_byte;
  logic              in_frame;
  logic [CNT_W-1:0]  cnt;
  logic [BYTE_W-1:0] sum;
  logic              wbank;
  logic              storing;
  logic              accept;

  assign storing  = in_frame && (cnt != CNT_W'(DATA_BYTES));
  assign s_tready = !(storing && bank_full[wbank]);
  assign accept   = s_tvalid && s_tready;

  assign we    = accept && storing;
  assign waddr = {wbank, cnt[IDX_W-1:0]};
  assign wdata = s_tdata;

  assign commit.commit = accept && in_frame && !storing && (s_tdata == sum);
  assign commit.bank   = wbank;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_RESET;
    end else if (cfg_wen) begin
      start_byte <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      cnt      <= '0;
      sum      <= '0;
      wbank    <= 1'b0;
    end else if (accept) begin
      if (!in_frame) begin
        if (s_tdata == start_byte) begin
          in_frame <= 1'b1;
          cnt      <= '0;
          sum      <= '0;
        end
      end else if (storing) begin
        cnt <= cnt + CNT_W'(1);
        sum <= sum + s_tdata;
      end else begin
        in_frame <= 1'b0;
        cnt      <= '0;
        sum      <= '0;
        if (commit.commit) begin
          wbank <= ~wbank;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  // never overwrite a bank still waiting to be sent
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    we |-> !bank_full[wbank]) else $error("write into full bank");
  // a good frame always flips to the other bank
  a_commit_flip: assert property (@(posedge clk) disable iff (rst)
    commit.commit |=> wbank != $past(wbank)) else $error("bank not flipped");
  // only data bytes can be held off
  a_ready_hunt: assert property (@(posedge clk) disable iff (rst)
    !storing |-> s_tready) else $error("ready low outside data");
`endif

endmodule

[design/sbcd_tx.sv]
// Transmit side: bank full flags and sequential read-out of committed frames.
module sbcd_tx (
  input  logic                         clk,
  input  logic                         rst,
  input  sbcd_pkg::sbcd_commit_t       commit,
  output logic [1:0]                   bank_full,
  output logic                         re,
  output logic [sbcd_pkg::ADDR_W-1:0]  raddr,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [sbcd_pkg::BIDX_W-1:0]  out_idx,
  output logic                         m_tlast
);
  import sbcd_pkg::*;

  logic             rbank;
  logic [IDX_W-1:0] ridx;
  logic             rlast;
  logic [1:0]       bank_full_next;

  assign rlast = (ridx == IDX_W'(DATA_BYTES - 1));
  assign re    = bank_full[rbank] && (!m_tvalid || m_tready);
  assign raddr = {rbank, ridx};

  always_comb begin
    bank_full_next = bank_full;
    if (re && rlast) begin
      bank_full_next[rbank] = 1'b0;
    end
    if (commit.commit) begin
      bank_full_next[commit.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_full <= '0;
      rbank     <= 1'b0;
      ridx      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      bank_full <= bank_full_next;
      if (re) begin
        m_tvalid <= 1'b1;
        if (rlast) begin
          ridx  <= '0;
          rbank <= ~rbank;
        end else begin
          ridx <= ridx + IDX_W'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      out_idx <= BIDX_W'(ridx);
      m_tlast <= rlast;
    end
  end

`ifndef ASSERT_OFF
  // a commit only lands on an empty bank
  a_commit_empty: assert property (@(posedge clk) disable iff (rst)
    commit.commit |-> !bank_full[commit.bank]) else $error("commit on full bank");
  // last marker only on the final position
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> out_idx == BIDX_W'(DATA_BYTES - 1))
    else $error("tlast at wrong index");
  // finishing a bank releases it and moves to the other one
  a_bank_done: assert property (@(posedge clk) disable iff (rst)
    re && rlast |=> rbank != $past(rbank) && !bank_full[$past(rbank)])
    else $error("bank not released");
`endif

endmodule

[design/start_byte_checksum_deframer_core.sv]
// Top level of the start-byte checksum deframer.
//
// Slave stream carries received bytes, one request per byte (s_tdata[7:0]).
// While hunting, a byte equal to the start register opens a frame; the next
// DATA_BYTES bytes are stored in a two-bank frame RAM and summed modulo 256,
// and the byte after them is the checksum. On a match the frame's bytes leave
// on the master stream in order, tlast on the final one; on a mismatch
// nothing leaves. Either way the block returns to hunting.
// Input takes one byte per cycle while s_tready is high. A good checksum
// sets the bank's full flag; its bytes then leave one per cycle while m_tready
// is high, via the RAM's registered read port, overlapping the next frame.
// s_tready drops only when a data byte would go into a bank whose frame still
// waits to be sent (two good frames pending because the receiver stalls);
// it rises again as soon as the older frame's last byte is read.
// The start register (cfg_wen/cfg_wdata) resets to 126. A synchronous rst
// returns to hunting and drops any pending frames; no RAM clearing is needed.
module start_byte_checksum_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [7:0] data_byte, [11:8] byte_index, zero pad
  output logic        m_tlast   // frame_last
);
  import sbcd_pkg::*;

  logic [1:0]        bank_full;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;
  logic [BIDX_W-1:0] out_idx;
  sbcd_commit_t      commit;

  sbcd_rx u_rx (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .bank_full (bank_full),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .commit    (commit)
  );

  sbcd_ram #(
    .WIDTH  (BYTE_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  sbcd_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .commit    (commit),
    .bank_full (bank_full),
    .re        (re),
    .raddr     (raddr),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_idx   (out_idx),
    .m_tlast   (m_tlast)
  );

  assign m_tdata = {4'b0000, out_idx, rdata};

endmodule
